// ----- rtl/rdf_pkg.sv -----
package rdf_pkg;

    localparam int unsigned DefWidth = 32;
    localparam int unsigned MinModulus = 15;

    typedef enum logic [1:0] {
        ST_OK      = 2'd0,
        ST_INVALID = 2'd1,
        ST_NOINV   = 2'd2
    } t_status;

    // datapath operations
    typedef enum logic [2:0] {
        OP_NONE,
        OP_LOAD,     // capture inputs
        OP_DIV,      // one restoring-division bit step (a / b)
        OP_MUL,      // one shift-add modular multiply step
        OP_EUC,      // commit one Euclid iteration
        OP_POW_SEL,  // choose next multiply of the exponentiation
        OP_POW_DONE  // commit multiply result to acc or base
    } t_op;

    typedef enum logic [3:0] {
        S_IDLE,
        S_CHECK,
        S_QDIV,
        S_PHI,
        S_PHIMUL,
        S_EINIT,
        S_EDIV,
        S_EMUL,
        S_ECOMMIT,
        S_PSEL,
        S_PMUL,
        S_PCOMMIT,
        S_OUT
    } t_state;

    typedef struct packed {
        t_op   op;
        logic  div_start;
        logic  mul_start;
        logic  [2:0] mul_src;  // which operands feed the multiplier
        logic  set_q;
        logic  set_phi;
        logic  euc_init;
        logic  pow_init;
    } t_cmd;

    // multiplier operand selects
    localparam logic [2:0] MS_PHI  = 3'd0;
    localparam logic [2:0] MS_EUC  = 3'd1;
    localparam logic [2:0] MS_ACC  = 3'd2;
    localparam logic [2:0] MS_SQR  = 3'd3;

    typedef struct packed {
        logic    invalid;
        logic    q_small;
        logic    div_busy;
        logic    mul_busy;
        logic    rcur_zero;
        logic    rprev_one;
        logic    exp_zero;
        logic    exp_bit;
        logic    pow_phase; // 0: acc multiply pending, 1: square pending
    } t_stat;

endpackage

// ----- rtl/rdf_ctrl.sv -----
module rdf_ctrl (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_valid,
    output logic          o_stall,
    output logic          o_valid,
    input  logic          i_stall,
    input  rdf_pkg::t_stat i_st,
    output rdf_pkg::t_cmd  o_cmd,
    output logic          o_fail,
    output logic          o_noinv
);
    import rdf_pkg::*;

    t_state r_state, n_state;
    logic   r_started, n_started;

    // state register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_started <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_started <= n_started;
        end
    end

    // next state and commands
    always_comb begin
        n_state   = r_state;
        n_started = 1'b0;
        o_cmd     = '0;
        o_cmd.op  = OP_NONE;
        o_stall   = 1'b1;
        o_valid   = 1'b0;
        o_fail    = 1'b0;
        o_noinv   = 1'b0;
        case (r_state)
            S_IDLE: begin
                o_stall = 1'b0;
                if (i_valid) begin
                    o_cmd.op = OP_LOAD;
                    n_state  = S_CHECK;
                end
            end
            S_CHECK: begin
                if (i_st.invalid) begin
                    o_fail  = 1'b1;
                    n_state = S_OUT;
                end else begin
                    o_cmd.div_start = 1'b1;
                    n_state = S_QDIV;
                end
            end
            S_QDIV: begin
                if (!i_st.div_busy) begin
                    o_cmd.set_q = 1'b1;
                    n_state = S_PHI;
                end else begin
                    o_cmd.op = OP_DIV;
                end
            end
            S_PHI: begin
                if (i_st.q_small) begin
                    o_fail  = 1'b1;
                    n_state = S_OUT;
                end else begin
                    o_cmd.mul_start = 1'b1;
                    o_cmd.mul_src   = MS_PHI;
                    n_state = S_PHIMUL;
                end
            end
            S_PHIMUL: begin
                o_cmd.mul_src = MS_PHI;
                if (!i_st.mul_busy) begin
                    o_cmd.set_phi = 1'b1;
                    n_state = S_EINIT;
                end else begin
                    o_cmd.op = OP_MUL;
                end
            end
            S_EINIT: begin
                o_cmd.euc_init = 1'b1;
                n_state = S_EDIV;
                n_started = 1'b1;
            end
            S_EDIV: begin
                if (r_started) begin
                    if (i_st.rcur_zero) begin
                        if (i_st.rprev_one) begin
                            o_cmd.pow_init = 1'b1;
                            n_state = S_PSEL;
                        end else begin
                            o_noinv = 1'b1;
                            n_state = S_OUT;
                        end
                    end else begin
                        o_cmd.div_start = 1'b1;
                    end
                end else if (!i_st.div_busy) begin
                    o_cmd.mul_start = 1'b1;
                    o_cmd.mul_src   = MS_EUC;
                    n_state = S_EMUL;
                end else begin
                    o_cmd.op = OP_DIV;
                    n_state = S_EDIV;
                end
            end
            S_EMUL: begin
                o_cmd.mul_src = MS_EUC;
                if (!i_st.mul_busy) begin
                    n_state = S_ECOMMIT;
                end else begin
                    o_cmd.op = OP_MUL;
                end
            end
            S_ECOMMIT: begin
                o_cmd.op  = OP_EUC;
                n_state   = S_EDIV;
                n_started = 1'b1;
            end
            S_PSEL: begin
                if (i_st.exp_zero && !i_st.pow_phase) begin
                    n_state = S_OUT;
                end else begin
                    o_cmd.op = OP_POW_SEL;
                    if (!i_st.pow_phase && !i_st.exp_bit) begin
                        n_state = S_PSEL;
                    end else begin
                        o_cmd.mul_start = 1'b1;
                        o_cmd.mul_src = i_st.pow_phase ? MS_SQR : MS_ACC;
                        n_state = S_PMUL;
                    end
                end
            end
            S_PMUL: begin
                o_cmd.mul_src = i_st.pow_phase ? MS_SQR : MS_ACC;
                if (!i_st.mul_busy) begin
                    n_state = S_PCOMMIT;
                end else begin
                    o_cmd.op = OP_MUL;
                end
            end
            S_PCOMMIT: begin
                o_cmd.op = OP_POW_DONE;
                n_state  = S_PSEL;
            end
            S_OUT: begin
                o_valid = 1'b1;
                if (!i_stall) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_OUT && i_stall) |=> (r_state == S_OUT))
        else $error("result dropped while stalled");
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_IDLE && i_valid) |=> (r_state == S_CHECK))
        else $error("accepted word not started");
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> o_stall)
        else $error("input taken while result pending");
endmodule

// ----- rtl/rdf_dp.sv -----
module rdf_dp #(
    parameter int unsigned WIDTH = rdf_pkg::DefWidth
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic [WIDTH-1:0] i_modulus,
    input  logic [WIDTH-1:0] i_prime_factor,
    input  logic [WIDTH-1:0] i_public_exponent,
    input  logic [WIDTH-1:0] i_ciphertext,
    input  rdf_pkg::t_cmd    i_cmd,
    input  logic             i_fail,
    input  logic             i_noinv,
    output rdf_pkg::t_stat   o_st,
    output logic [WIDTH-1:0] o_message,
    output logic [1:0]       o_status
);
    import rdf_pkg::*;

    localparam int unsigned CW = $clog2(WIDTH + 1);

    logic [WIDTH-1:0] r_n, r_p, r_e, r_c, r_q, r_phi;
    logic [WIDTH-1:0] r_rp, r_rc, r_tp, r_tc;
    logic [WIDTH-1:0] r_acc, r_base, r_exp;
    logic             r_phase;
    logic             r_qdone;
    logic [WIDTH-1:0] r_msg, n_msg;
    logic [1:0]       r_sts, n_sts;

    // divider: restoring, one quotient bit a cycle
    logic [WIDTH-1:0] r_dq, r_drem, r_dden, r_dsor;
    logic [CW-1:0]    r_dcnt;
    logic             r_dbusy;
    logic [WIDTH:0]   d_trial;

    // multiplier: shift-add mod m (plain product when m is zero), one bit a cycle
    logic [WIDTH-1:0] r_ma, r_mb, r_macc, r_mm;
    logic             r_mbusy;
    logic [WIDTH-1:0] s_ma, s_mb, s_mm;
    logic [WIDTH-1:0] m_sum, m_dbl;

    function automatic logic [WIDTH-1:0] f_addmod(
        input logic [WIDTH-1:0] x, input logic [WIDTH-1:0] y,
        input logic [WIDTH-1:0] m);
        logic [WIDTH-1:0] room;
        room = m - y;
        return (x >= room) ? (x - room) : (x + y);
    endfunction

    // multiplier operand select
    always_comb begin
        case (i_cmd.mul_src)
            MS_PHI: begin
                s_ma = r_p - 1'b1;
                s_mb = r_q - 1'b1;
                s_mm = '0; // plain product, wraps at WIDTH
            end
            MS_EUC: begin
                // t below phi, so the full quotient reduces on the fly
                s_ma = r_tc;
                s_mb = r_dq;
                s_mm = r_phi;
            end
            MS_ACC: begin
                s_ma = r_acc;
                s_mb = r_base;
                s_mm = r_n;
            end
            default: begin
                s_ma = r_base;
                s_mb = r_base;
                s_mm = r_n;
            end
        endcase
    end

    // modular add when modulus nonzero, plain add otherwise
    assign m_sum = (r_mm == '0) ? r_macc + r_ma : f_addmod(r_macc, r_ma, r_mm);
    assign m_dbl = (r_mm == '0) ? r_ma << 1 : f_addmod(r_ma, r_ma, r_mm);
    assign d_trial = {r_drem, r_dden[WIDTH-1]} - {1'b0, r_dsor};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_dbusy <= 1'b0;
            r_mbusy <= 1'b0;
        end else begin
            // divider; first divide is N / p, then Euclid steps
            if (i_cmd.div_start) begin
                r_dbusy <= 1'b1;
                r_dcnt  <= CW'(WIDTH);
                r_dq    <= '0;
                r_drem  <= '0;
                r_dden  <= r_qdone ? r_rp : r_n;
                r_dsor  <= r_qdone ? r_rc : r_p;
            end else if (i_cmd.op == OP_DIV) begin
                if (!d_trial[WIDTH]) begin
                    r_drem <= d_trial[WIDTH-1:0];
                    r_dq   <= {r_dq[WIDTH-2:0], 1'b1};
                end else begin
                    r_drem <= {r_drem[WIDTH-2:0], r_dden[WIDTH-1]};
                    r_dq   <= {r_dq[WIDTH-2:0], 1'b0};
                end
                r_dden <= r_dden << 1;
                r_dcnt <= r_dcnt - 1'b1;
                if (r_dcnt == CW'(1)) r_dbusy <= 1'b0;
            end
            // multiplier
            if (i_cmd.mul_start) begin
                r_mbusy <= 1'b1;
                r_ma    <= s_ma;
                r_mb    <= s_mb;
                r_mm    <= s_mm;
                r_macc  <= '0;
            end else if (i_cmd.op == OP_MUL) begin
                if (r_mb == '0) begin
                    r_mbusy <= 1'b0;
                end else begin
                    if (r_mb[0]) r_macc <= m_sum;
                    r_ma <= m_dbl;
                    r_mb <= r_mb >> 1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.op == OP_LOAD) begin
            r_n     <= i_modulus;
            r_p     <= i_prime_factor;
            r_e     <= i_public_exponent;
            r_c     <= i_ciphertext;
            r_qdone <= 1'b0;
            r_phi   <= '0;
            r_rc    <= '0;
        end
        if (i_cmd.set_q) begin
            r_q     <= r_dq;
            r_qdone <= 1'b1;
        end
        if (i_cmd.set_phi) r_phi <= r_macc;
        if (i_cmd.euc_init) begin
            r_rp <= r_phi;
            r_rc <= r_e;
            r_tp <= '0;
            r_tc <= (r_phi == WIDTH'(1)) ? '0 : WIDTH'(1);
        end
        if (i_cmd.op == OP_EUC) begin
            r_rp <= r_rc;
            r_rc <= r_drem;
            r_tp <= r_tc;
            r_tc <= (r_tp >= r_macc) ? r_tp - r_macc : r_tp + (r_phi - r_macc);
        end
        if (i_cmd.pow_init) begin
            r_acc   <= WIDTH'(1);
            r_base  <= (r_c == r_n) ? '0 : r_c;
            r_exp   <= r_tp;
            r_phase <= 1'b0;
        end
        if (i_cmd.op == OP_POW_SEL && !r_phase && !r_exp[0]) r_phase <= 1'b1;
        if (i_cmd.op == OP_POW_DONE) begin
            if (!r_phase) begin
                r_acc   <= r_macc;
                r_phase <= 1'b1;
            end else begin
                r_base  <= r_macc;
                r_exp   <= r_exp >> 1;
                r_phase <= 1'b0;
            end
        end
        r_msg <= n_msg;
        r_sts <= n_sts;
    end

    // result
    always_comb begin
        n_msg = r_msg;
        n_sts = r_sts;
        if (i_cmd.op == OP_LOAD) begin
            n_msg = '0;
            n_sts = ST_OK;
        end else if (i_fail) begin
            n_sts = ST_INVALID;
        end else if (i_noinv) begin
            n_sts = ST_NOINV;
        end else if (i_cmd.op == OP_POW_SEL || i_cmd.pow_init) begin
            n_msg = i_cmd.pow_init ? WIDTH'(1) : r_acc;
        end else if (i_cmd.op == OP_NONE && r_exp == '0 && !r_phase) begin
            n_msg = r_acc;
        end
    end

    // status to controller
    always_comb begin
        o_st.invalid  = (r_n < WIDTH'(MinModulus)) || (r_e == '0) || (r_c == '0)
                        || (r_c > r_n) || (r_p < WIDTH'(2));
        o_st.q_small  = r_q < WIDTH'(2);
        o_st.div_busy = r_dbusy;
        o_st.mul_busy = r_mbusy;
        o_st.rcur_zero = r_rc == '0;
        o_st.rprev_one = r_rp == WIDTH'(1);
        o_st.exp_zero = r_exp == '0;
        o_st.exp_bit  = r_exp[0];
        o_st.pow_phase = r_phase;
    end

    assign o_message = (r_sts == ST_OK) ? r_msg : '0;
    assign o_status  = r_sts;

    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cmd.op == OP_DIV) |-> r_dbusy)
        else $error("divide step while idle");
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cmd.op == OP_MUL) |-> r_mbusy)
        else $error("multiply step while idle");
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.div_start |=> r_dbusy)
        else $error("divider did not start");
endmodule

// ----- rtl/rsa_decrypt_from_factor.sv -----
// RSA decryption from one known prime factor.
// Input channel: i_valid / o_stall carry one word of modulus, prime factor,
// public exponent and ciphertext. A word is taken when i_valid is high and
// o_stall is low; o_stall stays high from acceptance until the result is taken.
// Output channel: o_valid / i_stall carry message and status (0 ok,
// 1 invalid input, 2 exponent not invertible modulo phi).
// Sequence: input rejected outright goes straight to the result, as does a
// cofactor below two after the division for q; otherwise a division for q,
// one multiply for phi, then per Euclid iteration a divide and a multiply,
// then up to two modular multiplies per exponent bit. The run time is set by
// the bit-serial divider and multiplier.
// One word is processed at a time; the next can be taken only after the result is taken.
// Reset (synchronous, active low) returns the controller to idle and drops
// any word in flight.
// While the receiver stalls, the result holds on the output and no new
// word is taken.
module rsa_decrypt_from_factor #(
    parameter int unsigned WIDTH = rdf_pkg::DefWidth
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_valid,
    output logic             o_stall,
    input  logic [WIDTH-1:0] i_modulus,
    input  logic [WIDTH-1:0] i_prime_factor,
    input  logic [WIDTH-1:0] i_public_exponent,
    input  logic [WIDTH-1:0] i_ciphertext,
    output logic             o_valid,
    input  logic             i_stall,
    output logic [WIDTH-1:0] o_message,
    output logic [1:0]       o_status
);
    import rdf_pkg::*;

    t_cmd  w_cmd;
    t_stat w_st;
    logic  w_fail, w_noinv;

    rdf_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .o_stall (o_stall),
        .o_valid (o_valid),
        .i_stall (i_stall),
        .i_st    (w_st),
        .o_cmd   (w_cmd),
        .o_fail  (w_fail),
        .o_noinv (w_noinv)
    );

    rdf_dp #(.WIDTH(WIDTH)) u_dp (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_modulus         (i_modulus),
        .i_prime_factor    (i_prime_factor),
        .i_public_exponent (i_public_exponent),
        .i_ciphertext      (i_ciphertext),
        .i_cmd             (w_cmd),
        .i_fail            (w_fail),
        .i_noinv           (w_noinv),
        .o_st              (w_st),
        .o_message         (o_message),
        .o_status          (o_status)
    );
endmodule
